@@ sv/iss_pkg.sv @@
package iss_pkg;

   // Fixed field widths of the request and response beats
   localparam int OP_W        = 4;
   localparam int POS_W       = 7;
   localparam int WORD_W      = 32;
   localparam int COUNT_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int REQ_TDATA_W = 48;
   localparam int RSP_TDATA_W = 48;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 4'd0,
      OP_PUSH_BACK  = 4'd1,
      OP_INSERT_AT  = 4'd2,
      OP_POP_FRONT  = 4'd3,
      OP_POP_BACK   = 4'd4,
      OP_REMOVE_AT  = 4'd5,
      OP_READ_AT    = 4'd6,
      OP_READ_FRONT = 4'd7,
      OP_READ_BACK  = 4'd8,
      OP_CLEAR      = 4'd9
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_EMPTY = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPEN_RD,
      S_OPEN_WR,
      S_PUT,
      S_TAKE,
      S_CLOSE_RD,
      S_CLOSE_WR,
      S_DONE
   } state_type;

   // Response item; data_out sits in the lowest bits
   typedef struct packed {
      status_type          status;
      logic [COUNT_W-1:0]  count_out;
      logic [WORD_W-1:0]   data_out;
   } rsp_type;

endpackage

@@ sv/iss_ram.sv @@
module iss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [AW-1:0]            wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [AW-1:0]            rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] cells_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= cells_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/iss_engine.sv @@
module iss_engine #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32,
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iss_pkg::OP_W-1:0]      req_op,
   input  logic [iss_pkg::POS_W-1:0]     req_position,
   input  logic [iss_pkg::WORD_W-1:0]    req_data_in,
   input  logic                          out_free,
   output logic                          rsp_load,
   output iss_pkg::rsp_type              rsp_item,
   output logic                          ram_wr_en,
   output logic [AW-1:0]                 ram_wr_addr,
   output logic [DATA_WIDTH-1:0]         ram_wr_data,
   output logic [AW-1:0]                 ram_rd_addr,
   input  logic [DATA_WIDTH-1:0]         ram_rd_data
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = ((CW > iss_pkg::POS_W) ? CW : iss_pkg::POS_W) + 1;

   iss_pkg::state_type            state_ff, state_in;
   logic [AW-1:0]                 idx_ff, idx_in;
   logic [AW-1:0]                 pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]         word_ff, word_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [iss_pkg::WORD_W-1:0]    res_ff, res_in;
   iss_pkg::status_type           status_ff, status_in;
   logic                          remove_ff, remove_in;

   iss_pkg::op_type               dec_op;
   iss_pkg::status_type           dec_status;
   logic [PW-1:0]                 dec_eff;
   logic                          dec_ins, dec_rem, dec_rd, dec_clr;
   logic [PW-1:0]                 cnt_w, pos_w, idx_w;
   logic                          full, empty;

   assign dec_op    = iss_pkg::op_type'(req_op);
   assign cnt_w     = PW'(count_ff);
   assign pos_w     = PW'(req_position);
   assign idx_w     = PW'(idx_ff);
   assign full      = cnt_w >= PW'(DEPTH);
   assign empty     = cnt_w == '0;
   assign req_ready = state_ff == iss_pkg::S_IDLE;

   // Decode the request: effective index, kind and status
   always_comb begin
      dec_eff    = pos_w;
      dec_status = iss_pkg::ST_OK;
      dec_ins    = 1'b0;
      dec_rem    = 1'b0;
      dec_rd     = 1'b0;
      dec_clr    = 1'b0;
      case (dec_op)
         iss_pkg::OP_PUSH_FRONT, iss_pkg::OP_PUSH_BACK, iss_pkg::OP_INSERT_AT: begin
            dec_ins = 1'b1;
            if (dec_op == iss_pkg::OP_PUSH_FRONT) begin
               dec_eff = '0;
            end else if (dec_op == iss_pkg::OP_PUSH_BACK) begin
               dec_eff = cnt_w;
            end
            if (dec_eff > cnt_w) begin
               dec_status = iss_pkg::ST_RANGE;
            end else if (full) begin
               dec_status = iss_pkg::ST_FULL;
            end
         end
         iss_pkg::OP_POP_FRONT, iss_pkg::OP_POP_BACK: begin
            dec_rem = 1'b1;
            dec_eff = (dec_op == iss_pkg::OP_POP_FRONT) ? '0 : cnt_w - PW'(1);
            if (empty) begin
               dec_status = iss_pkg::ST_EMPTY;
            end
         end
         iss_pkg::OP_REMOVE_AT: begin
            dec_rem = 1'b1;
            if (pos_w >= cnt_w) begin
               dec_status = iss_pkg::ST_RANGE;
            end
         end
         iss_pkg::OP_READ_AT: begin
            dec_rd = 1'b1;
            if (pos_w >= cnt_w) begin
               dec_status = iss_pkg::ST_RANGE;
            end
         end
         iss_pkg::OP_READ_FRONT, iss_pkg::OP_READ_BACK: begin
            dec_rd  = 1'b1;
            dec_eff = (dec_op == iss_pkg::OP_READ_FRONT) ? '0 : cnt_w - PW'(1);
            if (empty) begin
               dec_status = iss_pkg::ST_EMPTY;
            end
         end
         iss_pkg::OP_CLEAR: begin
            dec_clr = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Next state of the sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         iss_pkg::S_IDLE: begin
            if (req_valid) begin
               if (dec_status != iss_pkg::ST_OK) begin
                  state_in = iss_pkg::S_DONE;
               end else if (dec_ins) begin
                  state_in = (cnt_w > dec_eff) ? iss_pkg::S_OPEN_RD : iss_pkg::S_PUT;
               end else if (dec_rem || dec_rd) begin
                  state_in = iss_pkg::S_TAKE;
               end else begin
                  state_in = iss_pkg::S_DONE;
               end
            end
         end
         iss_pkg::S_OPEN_RD:  state_in = iss_pkg::S_OPEN_WR;
         iss_pkg::S_OPEN_WR: begin
            state_in = ((idx_w - PW'(1)) > PW'(pos_ff)) ? iss_pkg::S_OPEN_RD
                                                        : iss_pkg::S_PUT;
         end
         iss_pkg::S_PUT:      state_in = iss_pkg::S_DONE;
         iss_pkg::S_TAKE: begin
            state_in = (remove_ff && ((idx_w + PW'(1)) < cnt_w)) ? iss_pkg::S_CLOSE_RD
                                                                 : iss_pkg::S_DONE;
         end
         iss_pkg::S_CLOSE_RD: state_in = iss_pkg::S_CLOSE_WR;
         iss_pkg::S_CLOSE_WR: begin
            state_in = ((idx_w + PW'(2)) < cnt_w) ? iss_pkg::S_CLOSE_RD : iss_pkg::S_DONE;
         end
         iss_pkg::S_DONE: begin
            if (out_free) begin
               state_in = iss_pkg::S_IDLE;
            end
         end
         default: state_in = iss_pkg::S_IDLE;
      endcase
   end

   // Datapath controls, memory port and register updates
   always_comb begin
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      word_in     = word_ff;
      count_in    = count_ff;
      res_in      = res_ff;
      status_in   = status_ff;
      remove_in   = remove_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_addr = idx_ff;
      rsp_load    = 1'b0;
      case (state_ff)
         iss_pkg::S_IDLE: begin
            // Fetch the addressed word right away for read and remove
            ram_rd_addr = AW'(dec_eff);
            if (req_valid) begin
               idx_in    = dec_ins ? AW'(cnt_w) : AW'(dec_eff);
               pos_in    = AW'(dec_eff);
               word_in   = DATA_WIDTH'(req_data_in);
               remove_in = dec_rem;
               status_in = dec_status;
               res_in    = '0;
               if (dec_clr) begin
                  count_in = '0;
               end
            end
         end
         iss_pkg::S_OPEN_RD: begin
            ram_rd_addr = idx_ff - AW'(1);
         end
         iss_pkg::S_OPEN_WR: begin
            // Move one word toward the back
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            idx_in      = idx_ff - AW'(1);
         end
         iss_pkg::S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff;
            ram_wr_data = word_ff;
            count_in    = count_ff + CW'(1);
         end
         iss_pkg::S_TAKE: begin
            res_in = iss_pkg::WORD_W'(ram_rd_data);
            if (remove_ff && !((idx_w + PW'(1)) < cnt_w)) begin
               count_in = count_ff - CW'(1);
            end
         end
         iss_pkg::S_CLOSE_RD: begin
            ram_rd_addr = idx_ff + AW'(1);
         end
         iss_pkg::S_CLOSE_WR: begin
            // Move one word toward the front
            ram_wr_en   = 1'b1;
            ram_wr_addr = idx_ff;
            ram_wr_data = ram_rd_data;
            idx_in      = idx_ff + AW'(1);
            if (!((idx_w + PW'(2)) < cnt_w)) begin
               count_in = count_ff - CW'(1);
            end
         end
         iss_pkg::S_DONE: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_item.data_out  = res_ff;
   assign rsp_item.count_out = iss_pkg::COUNT_W'(count_ff);
   assign rsp_item.status    = status_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= iss_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      pos_ff    <= pos_in;
      word_ff   <= word_in;
      res_ff    <= res_in;
      status_ff <= status_in;
      remove_ff <= remove_in;
   end

endmodule

@@ sv/indexed_sequence_store_top.sv @@
// Insert moves count-position words toward the back before the new word is written.
// Remove moves count-1-position words toward the front after the word is read out.
// Throughput: one request at a time; the next request beat is taken once the
// sequencer is back in idle, while the output register may still hold a response.
// Reset clears the count and the control state; stored words are kept undefined.
module indexed_sequence_store_top #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // op [3:0], position [10:4], data_in [42:11], zero above
   input  logic [iss_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // data_out [31:0], count_out [38:32], status [40:39], zero above
   output logic [iss_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RSP_PAD = iss_pkg::RSP_TDATA_W - $bits(iss_pkg::rsp_type);

   logic                    out_valid_ff;
   iss_pkg::rsp_type        out_ff;
   logic                    out_free;
   logic                    rsp_load;
   iss_pkg::rsp_type        rsp_item;
   logic                    ram_wr_en;
   logic [AW-1:0]           ram_wr_addr;
   logic [DATA_WIDTH-1:0]   ram_wr_data;
   logic [AW-1:0]           ram_rd_addr;
   logic [DATA_WIDTH-1:0]   ram_rd_data;

   assign out_free = !out_valid_ff || rsp_tready;

   iss_engine #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .req_op       (req_tdata[3:0]),
      .req_position (req_tdata[10:4]),
      .req_data_in  (req_tdata[42:11]),
      .out_free     (out_free),
      .rsp_load     (rsp_load),
      .rsp_item     (rsp_item),
      .ram_wr_en    (ram_wr_en),
      .ram_wr_addr  (ram_wr_addr),
      .ram_wr_data  (ram_wr_data),
      .ram_rd_addr  (ram_rd_addr),
      .ram_rd_data  (ram_rd_data)
   );

   iss_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Hold the response beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         out_ff <= rsp_item;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{RSP_PAD{1'b0}}, out_ff};

endmodule

@@ sv/iss_checker.sv @@
module iss_checker #(
   parameter int DEPTH = 64
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   input  logic                              req_tready,
   input  logic [iss_pkg::REQ_TDATA_W-1:0]   req_tdata,
   input  logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic [iss_pkg::RSP_TDATA_W-1:0]   rsp_tdata
);

   // A stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // A failed request returns no data
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:39] != iss_pkg::ST_OK) |-> rsp_tdata[31:0] == '0)
      else $error("nonzero data with error status");

   // Full is reported only at full count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:39] == iss_pkg::ST_FULL)
         |-> rsp_tdata[38:32] == iss_pkg::COUNT_W'(DEPTH))
      else $error("full status with count below depth");

   // Empty is reported only at zero count
   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[40:39] == iss_pkg::ST_EMPTY) |-> rsp_tdata[38:32] == '0)
      else $error("empty status with nonzero count");

   // No new request is taken in the cycle right after one is taken
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while previous one in progress");

endmodule

bind indexed_sequence_store_top iss_checker #(.DEPTH(DEPTH)) u_iss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
